// ===== src/xild_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xild_pkg
// Shared types, constants and opcode bitmap tables for the length decoder.
// ----------------------------------------------------------------------------
package xild_pkg;

    localparam int WINDOW_BYTES = 16;

    typedef struct packed {
        logic [63:0] bytes_low;
        logic [63:0] bytes_high;
        logic [4:0]  avail_len;
    } in_beat_t;

    typedef struct packed {
        logic       found;
        logic [4:0] instr_len;
        logic [1:0] opcode_len;
        logic [4:0] arg_len;
        logic [3:0] prefix_count;
    } out_beat_t;

    // controller to datapath
    typedef struct packed {
        logic load;     // capture window, reset scan pointer
        logic step;     // consume current byte as prefix
        logic opc;      // latch current byte as opcode/escape
        logic finish;   // compute result from latched state
        logic fail;     // force not-found result
    } xild_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic have_byte;   // scan pointer inside window
        logic is_prefix;   // current byte is a legacy prefix
    } xild_stat_t;

    localparam logic [255:0] PREFIX_MAP = {
        32'h00000000, 32'h02020202, 32'h00000000, 32'h0F000000,
        32'h00000010, 32'h00000000, 32'h00000000, 32'h0000B000};
    localparam logic [255:0] ONE_MODRM_MAP = {
        32'hF0F0F0F0, 32'hF0F0F0F0, 32'h00000000, 32'h30500000,
        32'hFFFF0000, 32'h00000000, 32'hCF00F0FF, 32'h00000303};
    localparam logic [255:0] ONE_IMM8_MAP = {
        32'h08080808, 32'h08080808, 32'h00000000, 32'h0030FFFF,
        32'hB0000000, 32'h0080FF00, 32'hC2840C00, 32'hFF100000};
    localparam logic [255:0] ONE_IMMFULL_MAP = {
        32'h04040404, 32'h04040404, 32'h00000000, 32'h00C00000,
        32'h40000020, 32'h004000FF, 32'h01000000, 32'h00E00000};
    localparam logic [255:0] TWO_MODRM_MAP = {
        32'hF004FFFF, 32'h00FF0000, 32'hFFFFFFFF, 32'hFFFF8EFF,
        32'h0000FFFF, 32'h1C1FFFBF, 32'hFF00FFFF, 32'hFFFFFFFF};
    localparam logic [255:0] TWO_BAD_MAP = {
        32'h082B0000, 32'h050002FF, 32'h00000000, 32'h00000030,
        32'h00000000, 32'h03000000, 32'h007F0000, 32'h00000001};
    localparam logic [63:0] THREE38_OK_MAP = {32'h000F72F1, 32'h030F0200};

    // bit v of a table, msb of the first word is entry 0
    function automatic logic map_bit(input logic [255:0] map, input logic [7:0] v);
        map_bit = map[8'd255 - v];
    endfunction

endpackage

// ===== src/xild_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xild_ctrl
// Sequencer: accepts a window, walks prefixes one byte a cycle, then decodes.
// ----------------------------------------------------------------------------
module xild_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  xild_pkg::xild_stat_t stat,
    output xild_pkg::xild_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_PFX  = 4'b0010,
        S_DEC  = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_PFX;
                end
            end
            S_PFX:
            begin
                if (!stat.have_byte)
                begin
                    cmd.fail   = 1'b1;
                    state_next = S_OUT;
                end
                else if (stat.is_prefix)
                begin
                    cmd.step = 1'b1;
                end
                else
                begin
                    cmd.opc    = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                cmd.finish = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                in_ready  = out_ready;
                if (out_ready)
                begin
                    if (in_valid)
                    begin
                        cmd.load   = 1'b1;
                        state_next = S_PFX;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== src/xild_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xild_dp
// Datapath: window register, scan pointer, opcode decode and length sum.
// ----------------------------------------------------------------------------
module xild_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  xild_pkg::in_beat_t   in_beat,
    input  xild_pkg::xild_cmd_t  cmd,
    output xild_pkg::xild_stat_t stat,
    output xild_pkg::out_beat_t  out_beat
);

    logic [127:0] win_reg;
    logic [4:0]   len_reg;
    logic [4:0]   pos_reg;
    logic         osz_reg;
    logic         asz_reg;
    logic [7:0]   op_reg;
    xild_pkg::out_beat_t res_reg, res_next;

    logic [7:0] cur_byte;
    logic [4:0] len_clip;

    // byte at an absolute window offset, zero outside the window
    function automatic logic [7:0] win_byte(input logic [127:0] w, input logic [4:0] i);
        win_byte = i[4] ? 8'h00 : w[{i[3:0], 3'b000} +: 8];
    endfunction

    // valid 0f 38 opcodes below 0x40
    function automatic logic THREE_OK(input logic [7:0] v);
        THREE_OK = xild_pkg::THREE38_OK_MAP[6'd63 - v[5:0]];
    endfunction

    assign len_clip = (in_beat.avail_len > 5'(xild_pkg::WINDOW_BYTES))
                      ? 5'(xild_pkg::WINDOW_BYTES) : in_beat.avail_len;
    assign cur_byte = win_byte(win_reg, pos_reg);
    assign stat.have_byte = pos_reg < len_reg;
    assign stat.is_prefix = xild_pkg::map_bit(xild_pkg::PREFIX_MAP, cur_byte);
    assign out_beat = res_reg;

    // pointer and size override state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            osz_reg <= 1'b0;
            asz_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            pos_reg <= '0;
            osz_reg <= 1'b0;
            asz_reg <= 1'b0;
        end
        else if (cmd.step || cmd.opc)
        begin
            pos_reg <= pos_reg + 5'd1;
            if (cmd.step && cur_byte == 8'h66) osz_reg <= 1'b1;
            if (cmd.step && cur_byte == 8'h67) asz_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            win_reg <= {in_beat.bytes_high, in_beat.bytes_low};
            len_reg <= len_clip;
        end
        if (cmd.opc)
            op_reg <= cur_byte;
        res_reg <= res_next;
    end

    // opcode decode and length sum, pos_reg points just past first opcode byte
    always_comb
    begin
        logic [7:0] b1, b2, b3, b4, m, sib;
        logic [4:0] p, pm;
        logic       ok, modrm;
        logic [4:0] dsz, msz, tot, dfull, afull;
        logic [1:0] olen;
        b1 = win_byte(win_reg, pos_reg);
        b2 = win_byte(win_reg, pos_reg + 5'd1);
        b3 = win_byte(win_reg, pos_reg + 5'd2);
        b4 = win_byte(win_reg, pos_reg + 5'd3);
        dfull = osz_reg ? 5'd2 : 5'd4;
        afull = asz_reg ? 5'd2 : 5'd4;
        ok = 1'b1;
        dsz = '0;
        msz = '0;
        olen = 2'd1;
        p = pos_reg;
        modrm = 1'b0;
        m = b1;
        sib = b2;
        if (op_reg == 8'h0F)
        begin
            olen = 2'd2;
            p = pos_reg + 5'd1;
            if (pos_reg >= len_reg) ok = 1'b0;
            m = b2;
            sib = b3;
            if (b1 == 8'h38 || b1 == 8'h3A)
            begin
                olen = 2'd3;
                p = pos_reg + 5'd2;
                m = b3;
                sib = b4;
                if (pos_reg + 5'd1 >= len_reg) ok = 1'b0;
                modrm = 1'b1;
                if (b1 == 8'h38)
                begin
                    if (b2 < 8'h40)
                        ok = ok && THREE_OK(b2);
                    else
                        ok = ok && (b2 == 8'h40 || b2 == 8'h41 || b2 == 8'h80
                                    || b2 == 8'h81 || b2 == 8'hF0 || b2 == 8'hF1);
                end
                else
                begin
                    ok = ok && ((b2 >= 8'h08 && b2 < 8'h10) || (b2 >= 8'h14 && b2 < 8'h18)
                                || (b2 >= 8'h20 && b2 < 8'h23) || (b2 >= 8'h40 && b2 < 8'h43)
                                || (b2 >= 8'h60 && b2 < 8'h64));
                    dsz = 5'd1;
                end
            end
            else
            begin
                if (xild_pkg::map_bit(xild_pkg::TWO_BAD_MAP, b1)) ok = 1'b0;
                modrm = xild_pkg::map_bit(xild_pkg::TWO_MODRM_MAP, b1);
                if ((b1 >= 8'h70 && b1 < 8'h74) || b1 == 8'hA4 || b1 == 8'hAC
                    || b1 == 8'hBA || b1 == 8'hC2 || (b1 >= 8'hC4 && b1 < 8'hC7))
                    dsz = 5'd1;
                if (b1[7:4] == 4'h8) dsz = dsz + dfull;
            end
        end
        else
        begin
            modrm = xild_pkg::map_bit(xild_pkg::ONE_MODRM_MAP, op_reg);
            if (op_reg == 8'hF6 || op_reg == 8'hF7)
            begin
                if (pos_reg >= len_reg) ok = 1'b0;
                if (b1[5:3] == 3'b000) dsz = op_reg[0] ? dfull : 5'd1;
            end
            if (xild_pkg::map_bit(xild_pkg::ONE_IMM8_MAP, op_reg)) dsz = dsz + 5'd1;
            if (op_reg == 8'h9A || op_reg == 8'hC2 || op_reg == 8'hC8 || op_reg == 8'hCA
                || op_reg == 8'hEA)
                dsz = dsz + 5'd2;
            if (xild_pkg::map_bit(xild_pkg::ONE_IMMFULL_MAP, op_reg)) dsz = dsz + dfull;
            if ((op_reg & 8'hFC) == 8'hA0) msz = afull;
        end
        pm = p;
        if (modrm)
        begin
            if (p >= len_reg) ok = 1'b0;
            pm = p + 5'd1;
            if (m[7:6] != 2'b11)
            begin
                if (m[2:0] == 3'b100)
                begin
                    if (pm >= len_reg) ok = 1'b0;
                    pm = pm + 5'd1;
                    if (m[7:6] == 2'b00 && sib[2:0] == 3'b101) msz = msz + 5'd4;
                end
                if (m[7:6] == 2'b00)
                begin
                    if (m[2:0] == 3'b101) msz = msz + 5'd4;
                end
                else if (m[7:6] == 2'b01)
                    msz = msz + 5'd1;
                else
                    msz = msz + afull;
            end
        end
        tot = pm + dsz + msz;
        if (6'(pm) + 6'(dsz) + 6'(msz) > 6'(len_reg)) ok = 1'b0;
        res_next = res_reg;
        if (cmd.fail || (cmd.finish && !ok))
            res_next = '0;
        else if (cmd.finish)
        begin
            res_next.found        = 1'b1;
            res_next.instr_len    = tot;
            res_next.opcode_len   = olen;
            res_next.prefix_count = 4'(pos_reg - 5'd1);
            res_next.arg_len      = tot - (pos_reg - 5'd1) - 5'(olen);
        end
    end

endmodule

// ===== src/x86_instruction_length_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x86_instruction_length_decoder
// Length decoder for 32-bit x86 code: prefixes, opcode, modrm and immediates.
// ----------------------------------------------------------------------------
// usage
// - input channel in_valid/in_ready carries a 16-byte window and its length
// - output channel out_valid/out_ready returns one result beat per window
// - prefixes are walked one byte a cycle by the sequencer, then the opcode,
//   modrm/sib and immediate sizes are resolved in the decode state
// - an empty or prefix-only window ends in the walk with not-found
// - a new window is taken in the same cycle its predecessor's result leaves,
//   so windows are decoded one at a time
// - the prefix walk loop sets the rate: it examines one byte per cycle
// - when the receiver stalls the result holds and no input is taken
// - reset returns the sequencer to idle with no result pending
// ----------------------------------------------------------------------------
module x86_instruction_length_decoder (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  xild_pkg::in_beat_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output xild_pkg::out_beat_t out_data
);

    xild_pkg::xild_cmd_t  cmd;
    xild_pkg::xild_stat_t stat;

    xild_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    xild_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_beat  (in_data),
        .cmd      (cmd),
        .stat     (stat),
        .out_beat (out_data)
    );

endmodule

// ===== src/xild_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xild_checker
// Port-level checks on the length decoder, bound to the top level.
// ----------------------------------------------------------------------------
module xild_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input xild_pkg::out_beat_t out_data
);

    // not-found beats carry all zeros
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.found |-> out_data == '0)
        else $error("not-found beat has nonzero fields");

    // found beats add up
    a_sum: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.found |->
        out_data.instr_len == 5'(out_data.prefix_count) + 5'(out_data.opcode_len)
                              + out_data.arg_len && out_data.opcode_len != 2'd0)
        else $error("length fields inconsistent");

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed under stall");

    // no input taken while a result is stuck
    a_block: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input accepted during output stall");

    // a fresh window never shows a result in the next cycle
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !out_valid)
        else $error("result too early after input beat");

endmodule

bind x86_instruction_length_decoder xild_checker u_xild_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

// ===== tb/x86_instruction_length_decoder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x86_instruction_length_decoder_tb
// Self-checking bench for the x86 length decoder. A directed table covers
// window extremes, prefix handling, escape opcodes and truncation; random
// windows built from prefixes, opcodes and addressing bytes follow. Every
// result beat is checked against its table row or an in-bench length calculator.
// ----------------------------------------------------------------------------
module x86_instruction_length_decoder_tb;

    localparam int WD_LIMIT = 2000;
    localparam int N_RANDOM = 1580;

    typedef struct {
        logic [127:0]        win;
        logic [4:0]          len;
        bit                  typed;
        xild_pkg::out_beat_t res;
    } vec_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    xild_pkg::in_beat_t  in_data;
    logic                out_valid;
    logic                out_ready;
    xild_pkg::out_beat_t out_data;

    xild_pkg::out_beat_t len_q[$];
    vec_t      vecs[$];
    int        mismatches;
    int        idle_cycles;
    bit        no_idle;
    bit        hold_rx;
    bit        drive_done;

    x86_instruction_length_decoder dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic bit tbit(input logic [255:0] m, input int v);
        return m[255 - v];
    endfunction

    // instruction length calculation for one window
    function automatic xild_pkg::out_beat_t calc_len(input logic [127:0] win,
                                                     input logic [4:0] alen);
        xild_pkg::out_beat_t r;
        int lim, pos, b, op, n, dsz, asz, dsize, msize, olen, m, sib;
        bit modrm, ok;
        r = '0;
        lim = (alen > xild_pkg::WINDOW_BYTES) ? xild_pkg::WINDOW_BYTES : alen;
        pos = 0; n = 0; dsz = 4; asz = 4; dsize = 0; msize = 0; olen = 1;
        // prefix walk
        forever
        begin
            if (pos >= lim) return r;
            b = win[pos*8 +: 8];
            pos++;
            if (!tbit(xild_pkg::PREFIX_MAP, b)) break;
            n++;
            if (b == 'h66) dsz = 2;
            else if (b == 'h67) asz = 2;
        end
        op = b;
        if (op == 'h0F)
        begin
            if (pos >= lim) return r;
            op = win[pos*8 +: 8]; pos++;
            olen = 2;
            if (op == 'h38)
            begin
                if (pos >= lim) return r;
                op = win[pos*8 +: 8]; pos++;
                olen = 3;
                if (op < 'h40) ok = xild_pkg::THREE38_OK_MAP[63 - op];
                else ok = (op >= 'h40 && op < 'h42) || (op >= 'h80 && op < 'h82) ||
                          (op >= 'hF0 && op < 'hF2);
                if (!ok) return r;
                modrm = 1;
            end
            else if (op == 'h3A)
            begin
                if (pos >= lim) return r;
                op = win[pos*8 +: 8]; pos++;
                olen = 3;
                ok = (op >= 'h08 && op < 'h10) || (op >= 'h14 && op < 'h18) ||
                     (op >= 'h20 && op < 'h23) || (op >= 'h40 && op < 'h43) ||
                     (op >= 'h60 && op < 'h64);
                if (!ok) return r;
                modrm = 1;
                dsize += 1;
            end
            else
            begin
                if (tbit(xild_pkg::TWO_BAD_MAP, op)) return r;
                modrm = tbit(xild_pkg::TWO_MODRM_MAP, op);
                if ((op >= 'h70 && op < 'h74) || op == 'hA4 || op == 'hAC || op == 'hBA ||
                    op == 'hC2 || (op >= 'hC4 && op < 'hC7))
                    dsize += 1;
                if ((op & 'hF0) == 'h80) dsize += dsz;
            end
        end
        else
        begin
            modrm = tbit(xild_pkg::ONE_MODRM_MAP, op);
            // group 3 test form carries an immediate
            if (op == 'hF6 || op == 'hF7)
            begin
                if (pos >= lim) return r;
                m = win[pos*8 +: 8];
                if ((m & 'h38) == 0) dsize += (op & 1) ? dsz : 1;
            end
            if (tbit(xild_pkg::ONE_IMM8_MAP, op)) dsize += 1;
            if (op == 'h9A || op == 'hC2 || op == 'hC8 || op == 'hCA || op == 'hEA) dsize += 2;
            if (tbit(xild_pkg::ONE_IMMFULL_MAP, op)) dsize += dsz;
            if ((op & 'hFC) == 'hA0) msize += asz;
        end
        if (modrm)
        begin
            if (pos >= lim) return r;
            m = win[pos*8 +: 8]; pos++;
            if ((m & 'hC0) != 'hC0)
            begin
                if ((m & 7) == 4)
                begin
                    if (pos >= lim) return r;
                    sib = win[pos*8 +: 8]; pos++;
                    if ((m & 'hC0) == 0 && (sib & 7) == 5) msize += 4;
                end
                if ((m & 'hC0) == 0) begin if ((m & 7) == 5) msize += 4; end
                else if ((m & 'hC0) == 'h40) msize += 1;
                else msize += asz;
            end
        end
        pos += dsize + msize;
        if (pos > lim) return r;
        r.found = 1'b1;
        r.instr_len = 5'(pos);
        r.opcode_len = 2'(olen);
        r.arg_len = 5'(pos - n - olen);
        r.prefix_count = 4'(n);
        return r;
    endfunction

    function automatic logic [127:0] pack_bytes(input byte unsigned b[]);
        logic [127:0] w;
        w = {$urandom, $urandom, $urandom, $urandom};
        foreach (b[i]) w[i*8 +: 8] = b[i];
        return w;
    endfunction

    task automatic add_vec(input byte unsigned b[], input int len, input bit typed,
                           input xild_pkg::out_beat_t res);
        vec_t v;
        v.win = pack_bytes(b);
        v.len = 5'(len);
        v.typed = typed;
        v.res = res;
        vecs.push_back(v);
    endtask

    function automatic xild_pkg::out_beat_t mk(input int tot, input int ol, input int al,
                                               input int pc);
        xild_pkg::out_beat_t r;
        r.found = (tot != 0);
        r.instr_len = 5'(tot);
        r.opcode_len = 2'(ol);
        r.arg_len = 5'(al);
        r.prefix_count = 4'(pc);
        return r;
    endfunction

    // random window: mostly well-formed instruction starts
    function automatic vec_t rand_vec();
        vec_t v;
        byte unsigned b[16];
        int k, np;
        byte unsigned pfx[12] = '{'h26, 'h2E, 'h36, 'h3E, 'h64, 'h65, 'h66, 'h67,
                                  'h9B, 'hF0, 'hF2, 'hF3};
        foreach (b[i]) b[i] = $urandom;
        k = 0;
        if ($urandom_range(9) != 0)
        begin
            np = $urandom_range(3) == 0 ? $urandom_range(16) : $urandom_range(3);
            repeat (np) begin if (k < 16) b[k++] = pfx[$urandom_range(11)]; end
            if (k < 16)
            begin
                case ($urandom_range(5))
                    0: begin b[k++] = 'h0F; end
                    1: begin
                        b[k++] = 'h0F;
                        if (k < 16) b[k++] = $urandom_range(1) ? 'h38 : 'h3A;
                    end
                    2: b[k++] = 'hF6 | $urandom_range(1);
                    default: ;
                endcase
            end
            // bias modrm toward memory forms with sib/disp
            if (k < 16 && $urandom_range(1))
                b[k+1 < 16 ? k+1 : 15] = ($urandom_range(2) << 6) | ($urandom_range(1) ? 4 : 5);
        end
        v.win = {<<8{b}};
        v.win = {<<8{v.win}};
        for (int i = 0; i < 16; i++) v.win[i*8 +: 8] = b[i];
        v.len = ($urandom_range(7) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(16));
        v.typed = 0;
        return v;
    endfunction

    // reset, stimulus
    initial
    begin
        vec_t v;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        no_idle = 0;
        drive_done = 0;
        mismatches = 0;
        // directed table: typed rows can be read straight off the opcode maps
        add_vec('{'h90}, 0, 1, mk(0, 0, 0, 0));                 // empty window
        add_vec('{'h90}, 1, 1, mk(1, 1, 0, 0));                 // nop
        add_vec('{'h90}, 31, 1, mk(1, 1, 0, 0));                // oversized length
        add_vec('{'h66, 'h67, 'hF3}, 3, 1, mk(0, 0, 0, 0));     // prefixes only
        add_vec('{'h26, 'h2E, 'h36, 'h3E, 'h64, 'h65, 'h66, 'h67,
                  'h9B, 'hF0, 'hF2, 'hF3, 'h26, 'h2E, 'h36, 'h90}, 16, 1, mk(16, 1, 0, 15));
        add_vec('{'hB8, 1, 2, 3, 4}, 5, 1, mk(5, 1, 4, 0));     // mov eax, imm32
        add_vec('{'h66, 'hB8, 1, 2}, 4, 1, mk(4, 1, 2, 1));     // operand override
        add_vec('{'hB8, 1, 2, 3}, 4, 1, mk(0, 0, 0, 0));        // truncated
        add_vec('{'hA1, 1, 2, 3, 4}, 5, 1, mk(5, 1, 4, 0));     // moffs
        add_vec('{'h67, 'hA1, 1, 2}, 4, 1, mk(4, 1, 2, 1));     // address override
        add_vec('{'h0F, 'h0A}, 2, 1, mk(0, 0, 0, 0));           // invalid two-byte
        add_vec('{'h0F, 'h38, 'h0C, 'hC0}, 4, 1, mk(4, 3, 1, 0));
        add_vec('{'h0F, 'h38, 'hFF, 'hC0}, 4, 1, mk(0, 0, 0, 0));
        add_vec('{'h0F, 'h3A, 'h0F, 'hC0, 1}, 5, 1, mk(5, 3, 2, 0));
        add_vec('{'h0F, 'h3A, 'h00, 'hC0, 1}, 5, 1, mk(0, 0, 0, 0));
        add_vec('{'hF6, 'h00, 1}, 3, 1, mk(3, 1, 2, 0));        // test r/m8, imm8
        add_vec('{'hF7, 'hC0, 1, 2, 3, 4}, 6, 1, mk(6, 1, 5, 0));
        add_vec('{'hF7, 'hD8}, 2, 1, mk(2, 1, 1, 0));           // neg, no immediate
        add_vec('{'hF6}, 1, 1, mk(0, 0, 0, 0));                 // group 3 peek truncated
        add_vec('{'h8B, 'h04, 'h25, 1, 2, 3, 4}, 7, 1, mk(7, 1, 6, 0)); // sib disp32
        add_vec('{'h8B, 'h05, 1, 2, 3, 4}, 6, 1, mk(6, 1, 5, 0));
        add_vec('{'h67, 'h8B, 'h80, 1, 2}, 5, 1, mk(5, 1, 3, 1));
        add_vec('{'h0F, 'h84, 1, 2, 3, 4}, 6, 1, mk(6, 2, 4, 0));
        add_vec('{'hC8, 1, 2, 3}, 4, 1, mk(4, 1, 3, 0));        // enter
        v.win = '1; v.len = 16; v.typed = 0; vecs.push_back(v);
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int i = 0; i < vecs.size() + N_RANDOM; i++)
        begin
            if (i >= vecs.size()) v = rand_vec();
            else v = vecs[i];
            if (i == N_RANDOM * 3 / 4) no_idle = 1;
            // sender pause until every result is back
            if (i == 400 && len_q.size() != 0)
            begin
                in_valid <= 1'b0;
                while (len_q.size() != 0) @(posedge clk);
            end
            if (!no_idle && $urandom_range(5) == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
            in_valid <= 1'b1;
            in_data <= '{bytes_low: v.win[63:0], bytes_high: v.win[127:64], avail_len: v.len};
            @(posedge clk);
            while (!in_ready) @(posedge clk);
            len_q.push_back(v.typed ? v.res : calc_len(v.win, v.len));
            if (v.typed && calc_len(v.win, v.len) != v.res)
                $display("table row %0d disagrees with length calculator", i);
        end
        in_valid <= 1'b0;
        drive_done = 1;
    end

    // receiver: random stalls plus one long hold
    initial
    begin
        int cyc;
        out_ready = 1'b0;
        hold_rx = 0;
        cyc = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            cyc++;
            if (cyc == 3000)
            begin
                out_ready <= 1'b0;
                repeat (60) @(posedge clk);
            end
            if (!no_idle && $urandom_range(4) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // result check
    always @(posedge clk)
    begin
        xild_pkg::out_beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (len_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %p", out_data);
            end
            else
            begin
                want = len_q.pop_front();
                if (out_data !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p got %p", want, out_data);
                end
            end
        end
    end

    // watchdog and end of run
    initial
    begin
        idle_cycles = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WD_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
            if (drive_done && len_q.size() == 0)
            begin
                repeat (40) @(posedge clk);
                if (mismatches == 0 && len_q.size() == 0)
                    $display("PASS");
                else
                    $display("FAIL");
                $finish;
            end
        end
    end

endmodule
